// File: rtl/core/sab_pkg.sv
// Shared types and constants for the straight-alpha over blend.
// No dependencies; used by every module of the block.
package sab_pkg;

  localparam int unsigned ChW     = 8;   // one color or alpha channel
  localparam int unsigned DenW    = 16;  // 255*Ab + As*(255-Ab) <= 65025
  localparam int unsigned ProdW   = 24;  // channel times 16-bit weight
  localparam int unsigned QuoBits = 8;   // quotient never exceeds 255
  localparam int unsigned DivNW   = ProdW + 1;  // 2*num + den
  localparam int unsigned DivDW   = DenW + 1;   // 2*den
  // weights, products, dividend setup, then one stage per quotient bit
  localparam int unsigned NumStg  = 3 + QuoBits;
  localparam int unsigned StgDiv0 = 3;

  localparam logic [ChW-1:0] ChMax = 8'hFF;

  typedef struct packed {
    logic [NumStg-1:0] load;
  } sab_pipe_ctl_t;

  typedef struct packed {
    logic [DenW-1:0] wb;   // Ab * 255
    logic [DenW-1:0] ws;   // As * (255 - Ab)
    logic [DenW-1:0] den;  // wb + ws
  } sab_weight_t;

endpackage

// File: rtl/core/sab_if.sv
// Valid/ready channel interfaces for the input pixel pair and the result pixel.
// Depends on sab_pkg for the channel width.
interface sab_in_if import sab_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] back_red;
  logic [ChW-1:0] back_green;
  logic [ChW-1:0] back_blue;
  logic [ChW-1:0] back_alpha;
  logic [ChW-1:0] sprite_red;
  logic [ChW-1:0] sprite_green;
  logic [ChW-1:0] sprite_blue;
  logic [ChW-1:0] sprite_alpha;

  modport source (
    output valid, back_red, back_green, back_blue, back_alpha,
    output sprite_red, sprite_green, sprite_blue, sprite_alpha,
    input  ready
  );
  modport sink (
    input  valid, back_red, back_green, back_blue, back_alpha,
    input  sprite_red, sprite_green, sprite_blue, sprite_alpha,
    output ready
  );
endinterface

interface sab_out_if import sab_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] out_red;
  logic [ChW-1:0] out_green;
  logic [ChW-1:0] out_blue;
  logic [ChW-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// File: rtl/core/straight_alpha_over_blend.sv
// Straight-alpha over blend, background in front of sprite, one pixel per clock.
// Depends on sab_pkg, sab_if, sab_weight, sab_lane and sab_merge.
//
// Usage:
//   in_i carries one background and one sprite pixel (8-bit R, G, B, alpha)
//   per word; out_o carries the blended pixel with alpha fixed at 255.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   Each color is round-half-up of the alpha-weighted mix, exact; when both
//   alphas are zero the colors come out as zero.
//   A word accepted at a clock edge passes, in order, the weights (loaded
//   by the accepting edge), products, rounding setup, 8 divider bit stages
//   and output register before it appears on out_o valid. Throughput: one
//   word per cycle while out_o takes words, since the restoring divider is
//   fully pipelined, one quotient bit per stage in each lane.
//   Three lanes (red, green, blue) run in parallel and share the weight stage.
//   When out_o stalls, the word waits in the output register; the pipeline
//   keeps filling its empty stages and in_i stays ready until every stage
//   holds a word, then back-pressure reaches in_i.
//   Reset clears all valid flags; no word is in flight after reset.
module straight_alpha_over_blend import sab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sab_in_if.sink    in_i,
  sab_out_if.source out_o
);

  logic [NumStg-1:0] vld_d, vld_q;
  sab_pipe_ctl_t     ctl;
  logic              out_free;
  sab_weight_t       weight;
  logic [ChW-1:0]    res_red, res_green, res_blue;

  // each stage loads when empty or when the next stage moves on
  always_comb begin
    ctl.load[NumStg-1] = !vld_q[NumStg-1] || out_free;
    for (int k = NumStg - 2; k >= 0; k--) begin
      ctl.load[k] = !vld_q[k] || ctl.load[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (ctl.load[0]) begin
      vld_d[0] = in_i.valid;
    end
    for (int k = 1; k < NumStg; k++) begin
      if (ctl.load[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = ctl.load[0];

  sab_weight u_weight (
    .clk_i          (clk_i),
    .load_i         (ctl.load[0]),
    .back_alpha_i   (in_i.back_alpha),
    .sprite_alpha_i (in_i.sprite_alpha),
    .weight_o       (weight)
  );

  sab_lane u_lane_red (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .back_c_i   (in_i.back_red),
    .sprite_c_i (in_i.sprite_red),
    .weight_i   (weight),
    .result_o   (res_red)
  );

  sab_lane u_lane_green (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .back_c_i   (in_i.back_green),
    .sprite_c_i (in_i.sprite_green),
    .weight_i   (weight),
    .result_o   (res_green)
  );

  sab_lane u_lane_blue (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .back_c_i   (in_i.back_blue),
    .sprite_c_i (in_i.sprite_blue),
    .weight_i   (weight),
    .result_o   (res_blue)
  );

  sab_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NumStg-1]),
    .red_i   (res_red),
    .green_i (res_green),
    .blue_i  (res_blue),
    .free_o  (out_free),
    .out_o   (out_o)
  );

endmodule

// File: rtl/core/sab_weight.sv
// Shared front stage: layer weights and the blend denominator from both alphas.
// Depends on sab_pkg.
module sab_weight import sab_pkg::*; (
  input  logic           clk_i,
  input  logic           load_i,
  input  logic [ChW-1:0] back_alpha_i,
  input  logic [ChW-1:0] sprite_alpha_i,
  output sab_weight_t    weight_o
);

  logic [ChW-1:0]  inv;
  sab_weight_t     weight_d, weight_q;

  always_comb begin
    inv         = ChMax - back_alpha_i;
    // Ab * 255 as a shift and subtract
    weight_d.wb = {back_alpha_i, {ChW{1'b0}}} - {{(DenW-ChW){1'b0}}, back_alpha_i};
    weight_d.ws = {{(DenW-ChW){1'b0}}, sprite_alpha_i} * {{(DenW-ChW){1'b0}}, inv};
    weight_d.den = weight_d.wb + weight_d.ws;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      weight_q <= weight_d;
    end
  end

  assign weight_o = weight_q;

endmodule

// File: rtl/core/sab_lane.sv
// One color lane: weighted products, rounding setup, and a pipelined
// restoring divider giving one quotient bit per stage. Depends on sab_pkg.
module sab_lane import sab_pkg::*; (
  input  logic           clk_i,
  input  sab_pipe_ctl_t  ctl_i,
  input  logic [ChW-1:0] back_c_i,
  input  logic [ChW-1:0] sprite_c_i,
  input  sab_weight_t    weight_i,
  output logic [ChW-1:0] result_o
);

  logic [ChW-1:0]   bc_q, fc_q;
  logic [ProdW-1:0] pb_q, pf_q;
  logic [DenW-1:0]  den1_q;
  logic [DivNW-1:0] num_q;
  logic [DivDW-1:0] dvs_q;
  logic             zero_q;

  logic [DivNW-1:0]   rem_q [QuoBits-1];
  logic [DivDW-1:0]   dv_q  [QuoBits-1];
  logic [QuoBits-1:0] quo_q [QuoBits];
  logic               zr_q  [QuoBits];

  // stage 0: hold the channel pair next to the shared weights
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      bc_q <= back_c_i;
      fc_q <= sprite_c_i;
    end
  end

  // stage 1: both weighted products
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      pb_q   <= {{(ProdW-ChW){1'b0}}, bc_q} * {{(ProdW-DenW){1'b0}}, weight_i.wb};
      pf_q   <= {{(ProdW-ChW){1'b0}}, fc_q} * {{(ProdW-DenW){1'b0}}, weight_i.ws};
      den1_q <= weight_i.den;
    end
  end

  // stage 2: round half up as floor((2*num + den) / (2*den))
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      num_q  <= {(pb_q + pf_q), 1'b0} + {{(DivNW-DenW){1'b0}}, den1_q};
      dvs_q  <= {den1_q, 1'b0};
      zero_q <= (den1_q == '0);
    end
  end

  for (genvar j = 0; j < QuoBits; j++) begin : g_div
    logic [DivNW-1:0]   src_rem, sh_d, rem_nx;
    logic [DivDW-1:0]   src_d;
    logic [QuoBits-1:0] src_q;
    logic               src_z, ge;

    if (j == 0) begin : g_first
      assign src_rem = num_q;
      assign src_d   = dvs_q;
      assign src_q   = '0;
      assign src_z   = zero_q;
    end else begin : g_next
      assign src_rem = rem_q[j-1];
      assign src_d   = dv_q[j-1];
      assign src_q   = quo_q[j-1];
      assign src_z   = zr_q[j-1];
    end

    always_comb begin
      sh_d   = {{(DivNW-DivDW){1'b0}}, src_d} << (QuoBits - 1 - j);
      ge     = (src_rem >= sh_d);
      rem_nx = ge ? (src_rem - sh_d) : src_rem;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.load[StgDiv0 + j]) begin
        quo_q[j] <= {src_q[QuoBits-2:0], ge};
        zr_q[j]  <= src_z;
      end
    end

    if (j < QuoBits - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (ctl_i.load[StgDiv0 + j]) begin
          rem_q[j] <= rem_nx;
          dv_q[j]  <= src_d;
        end
      end
    end
  end

  // both alphas zero: force black
  assign result_o = zr_q[QuoBits-1] ? '0 : quo_q[QuoBits-1][ChW-1:0];

endmodule

// File: rtl/core/sab_merge.sv
// Merging stage: gathers the three lane results into one output word held
// in a register until taken. Depends on sab_pkg and sab_out_if.
module sab_merge import sab_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [ChW-1:0] red_i,
  input  logic [ChW-1:0] green_i,
  input  logic [ChW-1:0] blue_i,
  output logic           free_o,
  sab_out_if.source      out_o
);

  logic           valid_q;
  logic [ChW-1:0] red_q, green_q, blue_q;

  // register can take a new word when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_red   = red_q;
  assign out_o.out_green = green_q;
  assign out_o.out_blue  = blue_q;
  assign out_o.out_alpha = ChMax;

endmodule

// File: sim/testbench.sv
// Self-checking bench for straight_alpha_over_blend: directed alpha corners,
// then random pixel pairs.
// Needs sab_pkg, the sab_in_if/sab_out_if channel interfaces and the block RTL.
`timescale 1ns / 1ps

module testbench;
  import sab_pkg::*;

  localparam int unsigned NumRandom  = 1800;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 40;  // well past the pipeline depth

  typedef struct packed {
    logic [ChW-1:0] back_red;
    logic [ChW-1:0] back_green;
    logic [ChW-1:0] back_blue;
    logic [ChW-1:0] back_alpha;
    logic [ChW-1:0] sprite_red;
    logic [ChW-1:0] sprite_green;
    logic [ChW-1:0] sprite_blue;
    logic [ChW-1:0] sprite_alpha;
  } pixel_pair_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] alpha;
  } blended_px_t;

  typedef struct packed {
    pixel_pair_t pair;
    logic        fixed;  // px below is typed in, not predicted
    blended_px_t px;
  } corner_row_t;

  logic clk_i;
  logic rst_ni;

  sab_in_if  in_ch ();
  sab_out_if out_ch ();

  straight_alpha_over_blend dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  corner_row_t  corner_rows[$];
  blended_px_t  pending_px[$];
  int unsigned  err_count;
  int unsigned  checked_count;
  int unsigned  sent_count;
  int unsigned  cycle_cnt = 0;
  int unsigned  burst_left;
  int unsigned  hold_cnt = 0;
  logic         hold_ready = 1'b0;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  // Straight-alpha over, background in front, exact round half up.
  function automatic logic [ChW-1:0] mix_channel(logic [ChW-1:0] bc, logic [ChW-1:0] fc,
                                                 logic [ChW-1:0] ab, logic [ChW-1:0] as);
    longint unsigned b, f, a_b, a_s, inv, den, num, q;
    b   = bc;
    f   = fc;
    a_b = ab;
    a_s = as;
    inv = 255 - a_b;
    den = 255 * a_b + a_s * inv;
    num = b * a_b * 255 + f * a_s * inv;
    if (den == 0) return '0;
    q = (2 * num + den) / (2 * den);
    if (q > 255) q = 255;
    return q[ChW-1:0];
  endfunction

  function automatic blended_px_t predict_blend(pixel_pair_t p);
    blended_px_t r;
    r.red   = mix_channel(p.back_red,   p.sprite_red,   p.back_alpha, p.sprite_alpha);
    r.green = mix_channel(p.back_green, p.sprite_green, p.back_alpha, p.sprite_alpha);
    r.blue  = mix_channel(p.back_blue,  p.sprite_blue,  p.back_alpha, p.sprite_alpha);
    r.alpha = ChMax;
    return r;
  endfunction

  task automatic add_row(input logic [ChW-1:0] br, bg, bb, ba, sr, sg, sb, sa,
                         input logic fixed, input logic [ChW-1:0] er, eg, eb);
    corner_row_t row;
    row.pair  = {br, bg, bb, ba, sr, sg, sb, sa};
    row.fixed = fixed;
    row.px    = {er, eg, eb, ChMax};
    corner_rows.push_back(row);
  endtask

  // Lean on the alpha extremes; they steer the whole division.
  function automatic logic [ChW-1:0] rand_alpha();
    case ($urandom_range(0, 9))
      0, 1:    return 8'd0;
      2, 3:    return 8'd255;
      4:       return 8'd1;
      5:       return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ChW-1:0] rand_color();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one word in bursts with random gaps; hold until it is taken.
  task automatic send_pair(input pixel_pair_t p, input blended_px_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left = burst_left - 1;
    in_ch.valid        <= 1'b1;
    in_ch.back_red     <= p.back_red;
    in_ch.back_green   <= p.back_green;
    in_ch.back_blue    <= p.back_blue;
    in_ch.back_alpha   <= p.back_alpha;
    in_ch.sprite_red   <= p.sprite_red;
    in_ch.sprite_green <= p.sprite_green;
    in_ch.sprite_blue  <= p.sprite_blue;
    in_ch.sprite_alpha <= p.sprite_alpha;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_px.push_back(px);
    sent_count++;
  endtask

  initial begin
    pixel_pair_t p;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.back_red     = '0;
    in_ch.back_green   = '0;
    in_ch.back_blue    = '0;
    in_ch.back_alpha   = '0;
    in_ch.sprite_red   = '0;
    in_ch.sprite_green = '0;
    in_ch.sprite_blue  = '0;
    in_ch.sprite_alpha = '0;
    err_count     = 0;
    checked_count = 0;
    sent_count    = 0;
    burst_left    = 0;

    // Both alphas zero: colors drop to zero.
    add_row(8'd0,   8'd0,   8'd0,   8'd0, 8'd0,   8'd0,   8'd0,   8'd0, 1, 8'd0, 8'd0, 8'd0);
    add_row(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1, 8'd0, 8'd0, 8'd0);
    add_row(8'd170, 8'd85,  8'd1,   8'd0, 8'd85,  8'd170, 8'd254, 8'd0, 1, 8'd0, 8'd0, 8'd0);
    // Opaque background hides the sprite.
    add_row(8'd255, 8'd0,   8'd128, 8'd255, 8'd0, 8'd255, 8'd7,   8'd255, 1,
            8'd255, 8'd0, 8'd128);
    add_row(8'd12,  8'd200, 8'd99,  8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1,
            8'd12, 8'd200, 8'd99);
    add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1,
            8'd255, 8'd255, 8'd255);
    // Transparent background shows the sprite.
    add_row(8'd255, 8'd255, 8'd255, 8'd0, 8'd3,   8'd128, 8'd250, 8'd255, 1,
            8'd3, 8'd128, 8'd250);
    add_row(8'd0,   8'd77,  8'd255, 8'd0, 8'd255, 8'd0,   8'd64,  8'd1, 1,
            8'd255, 8'd0, 8'd64);
    // Any background alpha with sprite alpha zero keeps the background.
    add_row(8'd201, 8'd5,   8'd66,  8'd1, 8'd0,   8'd255, 8'd33,  8'd0, 1,
            8'd201, 8'd5, 8'd66);
    add_row(8'd90,  8'd180, 8'd255, 8'd128, 8'd255, 8'd0, 8'd0,   8'd0, 1,
            8'd90, 8'd180, 8'd255);
    // Mixed opacity, predicted.
    add_row(8'd255, 8'd0,   8'd128, 8'd128, 8'd0,   8'd255, 8'd127, 8'd128, 0, '0, '0, '0);
    add_row(8'd255, 8'd255, 8'd0,   8'd1,   8'd0,   8'd0,   8'd255, 8'd255, 0, '0, '0, '0);
    add_row(8'd0,   8'd0,   8'd255, 8'd254, 8'd255, 8'd255, 8'd0,   8'd255, 0, '0, '0, '0);
    add_row(8'd255, 8'd0,   8'd170, 8'd254, 8'd0,   8'd255, 8'd85,  8'd1,   0, '0, '0, '0);
    add_row(8'd255, 8'd255, 8'd255, 8'd1,   8'd0,   8'd0,   8'd0,   8'd1,   0, '0, '0, '0);
    add_row(8'd170, 8'd85,  8'd15,  8'd127, 8'd85,  8'd170, 8'd240, 8'd200, 0, '0, '0, '0);
    add_row(8'd1,   8'd2,   8'd4,   8'd64,  8'd8,   8'd16,  8'd32,  8'd192, 0, '0, '0, '0);
    add_row(8'd254, 8'd253, 8'd251, 8'd191, 8'd247, 8'd239, 8'd223, 8'd63,  0, '0, '0, '0);
    add_row(8'd100, 8'd101, 8'd102, 8'd2,   8'd200, 8'd201, 8'd202, 8'd3,   0, '0, '0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[i]) begin
      send_pair(corner_rows[i].pair,
                corner_rows[i].fixed ? corner_rows[i].px : predict_blend(corner_rows[i].pair));
    end

    for (int unsigned n = 0; n < NumRandom; n++) begin
      p.back_red     = rand_color();
      p.back_green   = rand_color();
      p.back_blue    = rand_color();
      p.back_alpha   = rand_alpha();
      p.sprite_red   = rand_color();
      p.sprite_green = rand_color();
      p.sprite_blue  = rand_color();
      p.sprite_alpha = rand_alpha();
      send_pair(p, predict_blend(p));
    end
    in_ch.valid <= 1'b0;

    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Blended %0d pixel pairs (%0d corner cases, rest random) under bursty input",
             sent_count, corner_rows.size());
    $display("and shifting output stalls; %0d results compared field by field.",
             checked_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output stall pattern steps through four modes as the cycle counter advances.
  always @(posedge clk_i) begin
    case ((cycle_cnt >> 11) & 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: begin
        if (hold_cnt == 0) begin
          hold_ready = ~hold_ready;
          hold_cnt   = $urandom_range(1, 24);
        end
        hold_cnt = hold_cnt - 1;
        out_ch.ready <= hold_ready;
      end
      default: out_ch.ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    blended_px_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected output word: red %0d green %0d blue %0d alpha %0d",
               out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha);
        err_count++;
      end else begin
        want = pending_px.pop_front();
        checked_count++;
        if (out_ch.out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_ch.out_red);
          err_count++;
        end
        if (out_ch.out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_ch.out_green);
          err_count++;
        end
        if (out_ch.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_ch.out_blue);
          err_count++;
        end
        if (out_ch.out_alpha !== want.alpha) begin
          $error("out_alpha: expected %0d, got %0d", want.alpha, out_ch.out_alpha);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_px.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/core/sab_pkg.sv
rtl/core/sab_if.sv
rtl/core/sab_weight.sv
rtl/core/sab_lane.sv
rtl/core/sab_merge.sv
rtl/core/straight_alpha_over_blend.sv
sim/testbench.sv
